### src/pesw_pkg.sv
// Shared widths, constants and control/status types for the edge span walker.
`timescale 1ns / 1ps

package pesw_pkg;

  localparam int unsigned X_W       = 12;
  localparam int unsigned Y_W       = 9;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned ACC_W     = X_W + FRAC_W;
  localparam int unsigned ROWS      = 512;
  localparam int unsigned ADDR_W    = $clog2(ROWS);
  localparam int unsigned DIV_CNT_W = $clog2(ACC_W);

  localparam logic [FRAC_W-1:0] CEIL_BIAS = FRAC_W'((1 << FRAC_W) - 1);

  typedef struct packed {
    logic load;       // capture an accepted item
    logic div_step;   // one restoring-division step
    logic walk_step;  // store one row and advance x
    logic rd_en;      // read both tables at the held row
    logic out_load;   // fill the result register
  } pesw_cmd_t;

  typedef struct packed {
    logic in_read;    // item on the input port is a read
    logic in_flat;    // item on the input port is a horizontal edge
    logic held_read;  // item being worked on is a read
    logic div_last;   // final quotient bit is being produced
    logic walk_last;  // current row is the last one of the edge
  } pesw_status_t;

endpackage

### src/pesw_ctrl.sv
// Controller state machine for the edge span walker.
`timescale 1ns / 1ps

module pesw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  pesw_pkg::pesw_status_t status_i,
  output pesw_pkg::pesw_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_READ,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.in_read) begin
            state_d = ST_READ;
          end else if (status_i.in_flat) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.walk_last) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/pesw_dp.sv
// Datapath: operand setup, serial divider, x accumulator, span tables and result register.
`timescale 1ns / 1ps

module pesw_dp (
  input  logic                           clk_i,
  input  logic                           action_i,
  input  logic [pesw_pkg::X_W-1:0]       start_x_i,
  input  logic [pesw_pkg::Y_W-1:0]       start_y_i,
  input  logic [pesw_pkg::X_W-1:0]       end_x_i,
  input  logic [pesw_pkg::Y_W-1:0]       end_y_i,
  input  logic [pesw_pkg::Y_W-1:0]       read_row_i,
  input  pesw_pkg::pesw_cmd_t            cmd_i,
  output pesw_pkg::pesw_status_t         status_o,
  output logic [pesw_pkg::X_W-1:0]       left_end_o,
  output logic [pesw_pkg::X_W-1:0]       right_end_o
);

  localparam int unsigned WIDE_W = pesw_pkg::ADDR_W + pesw_pkg::Y_W;

  logic                          is_read_q;
  logic                          side_q;
  logic                          neg_q;
  logic [pesw_pkg::Y_W-1:0]      row_q;
  logic [pesw_pkg::Y_W-1:0]      dy_q;
  logic [pesw_pkg::Y_W-1:0]      rem_q;
  logic [pesw_pkg::ACC_W-1:0]    dv_q;
  logic [pesw_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [pesw_pkg::ACC_W-1:0]    acc_q;
  logic [pesw_pkg::Y_W-1:0]      y_q;
  logic [pesw_pkg::Y_W-1:0]      yh_q;

  logic                          swap;
  logic [pesw_pkg::X_W-1:0]      xl, xh;
  logic [pesw_pkg::Y_W-1:0]      yl, yh;
  logic [pesw_pkg::X_W-1:0]      mag;

  logic [pesw_pkg::Y_W:0]        trial;
  logic                          ge;
  logic [pesw_pkg::ACC_W-1:0]    acc_d;

  logic [WIDE_W-1:0]             wy, ry;
  logic [pesw_pkg::ADDR_W-1:0]   waddr, raddr;
  logic                          w_in_range, r_in_range;
  logic [pesw_pkg::X_W-1:0]      wdata;

  logic [pesw_pkg::X_W-1:0]      left_mem  [pesw_pkg::ROWS];
  logic [pesw_pkg::X_W-1:0]      right_mem [pesw_pkg::ROWS];
  logic [pesw_pkg::X_W-1:0]      rd_left_q, rd_right_q;
  logic                          rd_ok_q;
  logic [pesw_pkg::X_W-1:0]      left_end_q, right_end_q;

  // Upward edges swap ends and go to the right table.
  assign swap = (end_y_i < start_y_i);
  assign xl   = swap ? end_x_i   : start_x_i;
  assign xh   = swap ? start_x_i : end_x_i;
  assign yl   = swap ? end_y_i   : start_y_i;
  assign yh   = swap ? start_y_i : end_y_i;
  assign mag  = (xh < xl) ? (xl - xh) : (xh - xl);

  // Restoring division on magnitudes, one quotient bit per step.
  assign trial = {rem_q, dv_q[pesw_pkg::ACC_W-1]};
  assign ge    = (trial >= {1'b0, dy_q});

  // Quotient magnitude sits in dv_q once division ends; apply the sign here.
  assign acc_d = neg_q ? (acc_q - dv_q) : (acc_q + dv_q);

  assign wy         = {{pesw_pkg::ADDR_W{1'b0}}, y_q};
  assign ry         = {{pesw_pkg::ADDR_W{1'b0}}, row_q};
  assign waddr      = wy[pesw_pkg::ADDR_W-1:0];
  assign raddr      = ry[pesw_pkg::ADDR_W-1:0];
  assign w_in_range = (wy < WIDE_W'(pesw_pkg::ROWS));
  assign r_in_range = (ry < WIDE_W'(pesw_pkg::ROWS));
  assign wdata      = acc_q[pesw_pkg::ACC_W-1:pesw_pkg::FRAC_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_read_q <= action_i;
      row_q     <= read_row_i;
      side_q    <= swap;
      neg_q     <= (xh < xl);
      dy_q      <= yh - yl;
      rem_q     <= '0;
      dv_q      <= {mag, {pesw_pkg::FRAC_W{1'b0}}};
      cnt_q     <= pesw_pkg::DIV_CNT_W'(pesw_pkg::ACC_W - 1);
      acc_q     <= {xl, pesw_pkg::CEIL_BIAS};
      y_q       <= yl;
      yh_q      <= yh;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? pesw_pkg::Y_W'(trial - {1'b0, dy_q}) : trial[pesw_pkg::Y_W-1:0];
      dv_q  <= {dv_q[pesw_pkg::ACC_W-2:0], ge};
      cnt_q <= cnt_q - 1'b1;
    end else if (cmd_i.walk_step) begin
      acc_q <= acc_d;
      y_q   <= y_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_step && w_in_range) begin
      if (side_q) begin
        right_mem[waddr] <= wdata;
      end else begin
        left_mem[waddr] <= wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_left_q  <= left_mem[raddr];
      rd_right_q <= right_mem[raddr];
      rd_ok_q    <= r_in_range;
    end
  end

  // Edge items answer zero; reads of rows beyond the table answer zero too.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      left_end_q  <= (is_read_q && rd_ok_q) ? rd_left_q  : '0;
      right_end_q <= (is_read_q && rd_ok_q) ? rd_right_q : '0;
    end
  end

  assign left_end_o  = left_end_q;
  assign right_end_o = right_end_q;

  assign status_o.in_read   = action_i;
  assign status_o.in_flat   = (start_y_i == end_y_i);
  assign status_o.held_read = is_read_q;
  assign status_o.div_last  = (cnt_q == '0);
  assign status_o.walk_last = (y_q == yh_q);

endmodule

### src/polygon_edge_span_walker.sv
// Top level of the polygon edge span walker: controller plus datapath.
// A read beat is loaded, reads both tables and fills the result register; a horizontal
// edge goes from load straight to the result. Other edges run a 28-step serial divider
// for the slope, then the walk writes one table row per cycle through one write port.
// Throughput: one item at a time; the next beat is taken once the result is in the
// output register, which holds it until the consumer takes it.
// Reset: rst_ni (async, active low) clears the FSM and output valid, not the span tables.
`timescale 1ns / 1ps

module polygon_edge_span_walker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic [pesw_pkg::X_W-1:0] start_x_i,
  input  logic [pesw_pkg::Y_W-1:0] start_y_i,
  input  logic [pesw_pkg::X_W-1:0] end_x_i,
  input  logic [pesw_pkg::Y_W-1:0] end_y_i,
  input  logic [pesw_pkg::Y_W-1:0] read_row_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [pesw_pkg::X_W-1:0] left_end_o,
  output logic [pesw_pkg::X_W-1:0] right_end_o
);

  // Command and status links between the controller and the datapath.
  pesw_pkg::pesw_cmd_t    cmd;
  pesw_pkg::pesw_status_t status;

  // Controller: sequences load, divide, walk or read, then hands the beat to
  // the result register when that register is free or draining.
  pesw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: swaps upward edges, divides dx<<16 by dy, steps the 12.16 x
  // value row by row into the left or right table, and reads rows back.
  pesw_dp u_dp (
    .clk_i       (clk_i),
    .action_i    (action_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .read_row_i  (read_row_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .left_end_o  (left_end_o),
    .right_end_o (right_end_o)
  );

  // At most one datapath command per cycle.
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.div_step, cmd.walk_step, cmd.rd_en, cmd.out_load}))
    else $error("more than one datapath command active");

  // The final division step is followed by the first walk step.
  a_div_to_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_step && status.div_last) |=> cmd.walk_step)
    else $error("walk did not start after division");

  // Edge beats always deliver zero span ends.
  a_edge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && !status.held_read) |=> (left_end_o == '0 && right_end_o == '0))
    else $error("edge result not zero");

  // No new beat is taken while the walk runs.
  a_no_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.walk_step |-> !in_ready_o)
    else $error("input ready during walk");

endmodule

### dv/testbench.sv
// Self-checking bench for the polygon edge span walker: random edges and row reads.
`timescale 1ns / 1ps

module testbench;

  // Item kinds on the input channel.
  localparam logic ACT_WALK = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam int unsigned X_MAX       = (1 << pesw_pkg::X_W) - 1;
  localparam int unsigned Y_MAX       = (1 << pesw_pkg::Y_W) - 1;
  localparam int unsigned RAND_BEATS  = 1200;
  localparam int unsigned CALM_TAIL   = 150;   // last beats run with no idling at all
  localparam int unsigned DRAIN_WAIT  = 64;
  // Slowest correct beat: a full-height walk plus the longest sender gap and the longest
  // result stall; about 1230 beats, then taken three times over.
  localparam longint CYCLE_LIMIT = 3 * 1230 * (2 + 28 + 512 + 18 + 18);

  typedef struct packed {
    logic                     action;
    logic [pesw_pkg::X_W-1:0] start_x;
    logic [pesw_pkg::Y_W-1:0] start_y;
    logic [pesw_pkg::X_W-1:0] end_x;
    logic [pesw_pkg::Y_W-1:0] end_y;
    logic [pesw_pkg::Y_W-1:0] read_row;
  } edge_beat_t;

  typedef struct packed {
    logic [pesw_pkg::X_W-1:0] left_x;
    logic [pesw_pkg::X_W-1:0] right_x;
  } span_ends_t;

  // Keeps a private copy of both span tables, predicts each result beat and
  // checks the block's results against them in order.
  class edge_span_board;
    logic [pesw_pkg::X_W-1:0] left_copy  [pesw_pkg::ROWS];
    logic [pesw_pkg::X_W-1:0] right_copy [pesw_pkg::ROWS];
    bit                       left_set   [pesw_pkg::ROWS];
    bit                       right_set  [pesw_pkg::ROWS];
    span_ends_t               pending_ends[$];
    int unsigned              failures;
    int unsigned              walks;
    int unsigned              flat_walks;
    int unsigned              reads;
    longint                   rows_walked;

    function new();
      failures    = 0;
      walks       = 0;
      flat_walks  = 0;
      reads       = 0;
      rows_walked = 0;
      foreach (left_set[i]) begin
        left_set[i]  = 1'b0;
        right_set[i] = 1'b0;
      end
    endfunction

    // Step x down the edge in 12.16, flooring each row into one of the tables.
    function void walk_edge_rows(edge_beat_t b);
      longint xl, yl, xh, yh, tmp, dy, slope, acc, y;
      bit     upward;
      if (b.start_y == b.end_y) begin
        flat_walks++;
        return;
      end
      xl     = longint'(b.start_x);
      yl     = longint'(b.start_y);
      xh     = longint'(b.end_x);
      yh     = longint'(b.end_y);
      upward = 1'b0;
      if (yh < yl) begin
        upward = 1'b1;
        tmp = xl; xl = xh; xh = tmp;
        tmp = yl; yl = yh; yh = tmp;
      end
      dy    = yh - yl;
      slope = ((xh - xl) * (longint'(1) << pesw_pkg::FRAC_W)) / dy;  // truncates toward zero
      acc   = (xl << pesw_pkg::FRAC_W) + longint'(pesw_pkg::CEIL_BIAS);
      for (y = yl; y <= yh; y++) begin
        if (y < pesw_pkg::ROWS) begin
          if (upward) begin
            right_copy[y] = pesw_pkg::X_W'(acc >>> pesw_pkg::FRAC_W);
            right_set[y]  = 1'b1;
          end else begin
            left_copy[y] = pesw_pkg::X_W'(acc >>> pesw_pkg::FRAC_W);
            left_set[y]  = 1'b1;
          end
        end
        acc = acc + slope;
        rows_walked++;
      end
    endfunction

    function bit row_readable(int unsigned r);
      return left_set[r] && right_set[r];
    endfunction

    function int unsigned pending();
      return pending_ends.size();
    endfunction

    // Note one accepted input beat and queue the result it must produce.
    function void note_beat(edge_beat_t b);
      span_ends_t ends;
      ends = '0;
      if (b.action == ACT_READ) begin
        reads++;
        if (b.read_row < pesw_pkg::ROWS) begin
          ends.left_x  = left_copy[b.read_row];
          ends.right_x = right_copy[b.read_row];
        end
      end else begin
        walks++;
        walk_edge_rows(b);
      end
      pending_ends.push_back(ends);
    endfunction

    // Compare one accepted result beat with the oldest prediction.
    function void check_ends(logic [pesw_pkg::X_W-1:0] left_got,
                             logic [pesw_pkg::X_W-1:0] right_got);
      span_ends_t want;
      if (pending_ends.size() == 0) begin
        $display("%0t: unexpected result beat left_end=%0d right_end=%0d",
                 $time, left_got, right_got);
        failures++;
        return;
      end
      want = pending_ends.pop_front();
      if (left_got !== want.left_x) begin
        $display("%0t: left_end mismatch expected %0d actual %0d",
                 $time, want.left_x, left_got);
        failures++;
      end
      if (right_got !== want.right_x) begin
        $display("%0t: right_end mismatch expected %0d actual %0d",
                 $time, want.right_x, right_got);
        failures++;
      end
    endfunction
  endclass

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     action_i    = ACT_WALK;
  logic [pesw_pkg::X_W-1:0] start_x_i   = '0;
  logic [pesw_pkg::Y_W-1:0] start_y_i   = '0;
  logic [pesw_pkg::X_W-1:0] end_x_i     = '0;
  logic [pesw_pkg::Y_W-1:0] end_y_i     = '0;
  logic [pesw_pkg::Y_W-1:0] read_row_i  = '0;
  logic                     out_ready_i = 1'b0;
  logic                     in_ready_o;
  logic                     out_valid_o;
  logic [pesw_pkg::X_W-1:0] left_end_o;
  logic [pesw_pkg::X_W-1:0] right_end_o;

  edge_span_board board = new();
  longint         cycle_count = 0;
  bit             tx_idle_en = 1'b0;
  bit             rx_idle_en = 1'b0;
  int             rx_stall_left = 0;

  polygon_edge_span_walker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .read_row_i  (read_row_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .left_end_o  (left_end_o),
    .right_end_o (right_end_o)
  );

  always #5 clk_i = ~clk_i;

  // Bound the run; a hang anywhere lands here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, board.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // Check every result beat taken at this edge against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_ends(left_end_o, right_end_o);
    end
  end

  // Drive result-side backpressure: stall in bursts at random while enabled.
  always @(negedge clk_i) begin
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready_i <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      rx_stall_left = $urandom_range(1, 18) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Offer one beat from a falling edge; hold it until taken, return at a falling edge.
  task automatic send_beat(edge_beat_t b);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= b.action;
    start_x_i  <= b.start_x;
    start_y_i  <= b.start_y;
    end_x_i    <= b.end_x;
    end_y_i    <= b.end_y;
    read_row_i <= b.read_row;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_beat(b);
    @(negedge clk_i);
  endtask

  task automatic send_walk(int unsigned sx, int unsigned sy, int unsigned ex, int unsigned ey);
    edge_beat_t b;
    b.action   = ACT_WALK;
    b.start_x  = pesw_pkg::X_W'(sx);
    b.start_y  = pesw_pkg::Y_W'(sy);
    b.end_x    = pesw_pkg::X_W'(ex);
    b.end_y    = pesw_pkg::Y_W'(ey);
    b.read_row = pesw_pkg::Y_W'($urandom);  // don't care on a walk, toggle it anyway
    send_beat(b);
  endtask

  task automatic send_read(int unsigned r);
    edge_beat_t b;
    b.action   = ACT_READ;
    b.start_x  = pesw_pkg::X_W'($urandom);  // endpoints are don't care on a read
    b.start_y  = pesw_pkg::Y_W'($urandom);
    b.end_x    = pesw_pkg::X_W'($urandom);
    b.end_y    = pesw_pkg::Y_W'($urandom);
    b.read_row = pesw_pkg::Y_W'(r);
    send_beat(b);
  endtask

  // Random walk: mostly short edges of tens of rows, some horizontal, some anywhere.
  task automatic send_random_walk();
    int unsigned kind, pick;
    int          sx, sy, ex, ey, span;
    kind = $urandom_range(0, 99);
    sx   = $urandom_range(0, X_MAX);
    ex   = $urandom_range(0, X_MAX);
    sy   = $urandom_range(0, Y_MAX);
    if (kind < 10) begin
      ey = sy;
    end else if (kind < 25) begin
      ey = $urandom_range(0, Y_MAX);
    end else begin
      span = $urandom_range(1, 40);
      ey   = ($urandom_range(0, 1) == 1) ? sy + span : sy - span;
      if (ey > int'(Y_MAX)) ey = sy - span;
      if (ey < 0) ey = sy + span;
      pick = $urandom_range(0, 3);
      if (pick == 0) begin
        ex = sx + $urandom_range(0, 16) - 8;
        if (ex < 0) ex = 0;
        if (ex > int'(X_MAX)) ex = X_MAX;
      end else if (pick == 1) begin
        ex = ($urandom_range(0, 1) == 1) ? X_MAX : 0;
      end
    end
    send_walk(sx, sy, ex, ey);
  endtask

  // Read a row that both tables already hold.
  task automatic send_random_read();
    int unsigned r;
    do r = $urandom_range(0, pesw_pkg::ROWS - 1); while (!board.row_readable(r));
    send_read(r);
  endtask

  initial begin
    int unsigned i;

    // Hold reset low, then release it on a falling edge.
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: fill both tables over the full height first so every later read is legal.
    send_walk(0, 0, X_MAX, Y_MAX);         // downward, steepest rise over all rows
    send_walk(0, Y_MAX, X_MAX, 0);         // upward, swapped, falling x into right table
    send_read(0);
    send_read(Y_MAX);
    send_read(255);
    send_walk(0, 100, X_MAX, 100);         // horizontal edge does nothing
    send_walk(X_MAX, 10, X_MAX, 20);       // vertical edge at the top x
    send_read(15);
    send_walk(0, 300, X_MAX, 301);         // one-row step, largest slope
    send_read(300);
    send_read(301);
    send_walk(X_MAX, 401, 0, 400);         // upward one-row step, swapped into largest slope
    send_read(400);
    send_read(401);
    send_walk(X_MAX, 0, 0, Y_MAX);         // downward with falling x
    send_walk(0, Y_MAX, 0, 0);             // upward vertical edge at x zero
    send_walk(1, 0, 2, Y_MAX);             // shallow slope, rounding at every row
    send_walk(7, 200, 0, 203);             // small negative slope truncating toward zero
    send_read(0);
    send_read(Y_MAX);
    send_read(201);
    send_read(256);

    // Random part, in segments that switch idling on and off.
    for (i = 0; i < RAND_BEATS; i++) begin
      tx_idle_en = (i < RAND_BEATS - CALM_TAIL) && ((i / 150) % 4 != 2);
      rx_idle_en = (i < RAND_BEATS - CALM_TAIL) && ((i / 150) % 4 != 1);
      if (i == 300 || i == 700) begin
        // Hold off the sender until every outstanding result has drained.
        in_valid_i <= 1'b0;
        while (board.pending() != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 99) < 40) send_random_read();
      else send_random_walk();
    end

    // Drop valid, drain, then keep waiting for stray results.
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (board.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.pending());
      board.failures++;
    end

    $display("Covered %0d edge walks (%0d horizontal, %0d rows stepped) and %0d row reads.",
             board.walks, board.flat_walks, board.rows_walked, board.reads);
    $display("Ran %0d cycles with bursty stalls on both channels and %0d mismatches.",
             cycle_count, board.failures);
    if (board.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
src/pesw_pkg.sv
src/pesw_ctrl.sv
src/pesw_dp.sv
src/polygon_edge_span_walker.sv
dv/testbench.sv
